>>> rtl/esmv_pkg.sv
// ----------------------------------------------------------------------------
// esmv_pkg: shared types and constants for the ELLPACK matrix-vector block
// Widths of the vector store, slot codes and the per-slot control bundle.
// ----------------------------------------------------------------------------
package esmv_pkg;

    localparam int VEC_DEPTH = 1024;
    localparam int VEC_AW    = $clog2(VEC_DEPTH);
    localparam int VLEN_W    = 11;
    localparam int ROW_W     = 16;
    localparam int VAL_W     = 32;
    localparam int ACC_W     = 64;

    localparam logic [VLEN_W-1:0] VLEN_RESET = VLEN_W'(1024);
    localparam logic [VLEN_W-1:0] COUNT_MAX  = {VLEN_W{1'b1}};
    localparam logic [VLEN_W-1:0] PAD_COLUMN = {VLEN_W{1'b1}};

    // Request kinds carried on tuser
    localparam logic REQ_VECTOR = 1'b0;
    localparam logic REQ_SLOT   = 1'b1;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic used;   // slot contributes a product
        logic bad;    // slot column unusable
        logic last;   // last slot of its row
        logic dim;    // vector count mismatch seen at accept
    } t_slot_ctl;

endpackage

>>> rtl/ellpack_sparse_matvec.sv
// Path: a row sum appears on the master side after the edge that transfers its
// last slot, via the vector read, product register and accumulate into result register.
// Throughput: one transfer per cycle, vector writes and row slots alike, unless master
// back-pressure stalls; the 1024-entry vector memory has one write and one read port.
// Reset: synchronous active low; clears the loaded count, accumulator, flags
// and row number, sets vector_length to 1024; vector memory is not cleared.
// ----------------------------------------------------------------------------
// ellpack_sparse_matvec: ELLPACK sparse matrix times dense vector
// Loads vector elements, then sums value*element per row in saturating Q32.32.
// ----------------------------------------------------------------------------
module ellpack_sparse_matvec (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // write channel for vector_length
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data,
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [9:0] vector_address, [41:10] vector_value, [52:42] entry_column,
    // [84:53] entry_value, [87:85] zero
    input  logic [87:0] s_axis_tdata,
    // [0] req_type
    input  logic        s_axis_tuser,
    // row_end
    input  logic        s_axis_tlast,
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] row_number, [79:16] row_sum, [80] saturated, [81] bad_column,
    // [82] dimension_error, [87:83] zero
    output logic [87:0] m_axis_tdata
);

    logic [esmv_pkg::VLEN_W-1:0] r_vec_len;

    logic                               w_accept;
    logic                               w_is_slot;
    logic [esmv_pkg::VEC_AW-1:0]        w_vaddr;
    logic [esmv_pkg::VAL_W-1:0]         w_vvalue;
    logic [esmv_pkg::VLEN_W-1:0]        w_col;
    logic [esmv_pkg::VAL_W-1:0]         w_evalue;
    logic                               w_is_pad;
    logic                               w_col_bad;
    logic [esmv_pkg::VLEN_W-1:0]        w_loaded;
    esmv_pkg::t_slot_ctl                w_ctl;

    logic                               r_s1_valid;
    esmv_pkg::t_slot_ctl                r_s1_ctl;
    logic signed [esmv_pkg::VAL_W-1:0]  r_s1_value;
    logic [esmv_pkg::VAL_W-1:0]         w_x;
    logic                               w_acc_ready;

    logic [esmv_pkg::ROW_W-1:0]         w_row_number;
    logic [esmv_pkg::ACC_W-1:0]         w_row_sum;
    logic                               w_sat;
    logic                               w_bad;
    logic                               w_dim;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec_len <= esmv_pkg::VLEN_RESET;
        end else if (i_cfg_valid) begin
            r_vec_len <= i_cfg_data;
        end
    end

    assign w_vaddr   = s_axis_tdata[9:0];
    assign w_vvalue  = s_axis_tdata[41:10];
    assign w_col     = s_axis_tdata[52:42];
    assign w_evalue  = s_axis_tdata[84:53];
    assign w_is_slot = (s_axis_tuser == esmv_pkg::REQ_SLOT);

    assign s_axis_tready = !r_s1_valid || w_acc_ready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // negative columns other than padding, and columns past either limit
    assign w_is_pad  = (w_col == esmv_pkg::PAD_COLUMN);
    assign w_col_bad = !w_is_pad &&
                       (w_col[esmv_pkg::VLEN_W-1] || (w_col >= r_vec_len) ||
                        (w_col >= esmv_pkg::VLEN_W'(esmv_pkg::VEC_DEPTH)));

    always_comb begin
        w_ctl.used = !w_is_pad && !w_col_bad;
        w_ctl.bad  = w_col_bad;
        w_ctl.last = s_axis_tlast;
        w_ctl.dim  = (w_loaded != r_vec_len);
    end

    esmv_vec_store u_store (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr_en        (w_accept && !w_is_slot),
        .i_wr_addr      (w_vaddr),
        .i_wr_data      (w_vvalue),
        .i_rd_en        (w_accept && w_is_slot),
        .i_rd_addr      (w_col[esmv_pkg::VEC_AW-1:0]),
        .o_rd_data      (w_x),
        .o_loaded_count (w_loaded)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= w_accept && w_is_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_is_slot) begin
            r_s1_ctl   <= w_ctl;
            r_s1_value <= w_evalue;
        end
    end

    esmv_row_accum u_accum (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (r_s1_valid),
        .o_ready           (w_acc_ready),
        .i_ctl             (r_s1_ctl),
        .i_value           (r_s1_value),
        .i_x               (w_x),
        .o_valid           (m_axis_tvalid),
        .i_ready           (m_axis_tready),
        .o_row_number      (w_row_number),
        .o_row_sum         (w_row_sum),
        .o_saturated       (w_sat),
        .o_bad_column      (w_bad),
        .o_dimension_error (w_dim)
    );

    assign m_axis_tdata = {5'b0, w_dim, w_bad, w_sat, w_row_sum, w_row_number};

endmodule

>>> rtl/esmv_vec_store.sv
// ----------------------------------------------------------------------------
// esmv_vec_store: dense vector memory with registered read
// Holds the vector elements and counts how many have been loaded.
// ----------------------------------------------------------------------------
module esmv_vec_store (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr_en,
    input  logic [esmv_pkg::VEC_AW-1:0]       i_wr_addr,
    input  logic [esmv_pkg::VAL_W-1:0]        i_wr_data,
    input  logic                              i_rd_en,
    input  logic [esmv_pkg::VEC_AW-1:0]       i_rd_addr,
    output logic [esmv_pkg::VAL_W-1:0]        o_rd_data,
    output logic [esmv_pkg::VLEN_W-1:0]       o_loaded_count
);

    logic [esmv_pkg::VAL_W-1:0]  r_mem [esmv_pkg::VEC_DEPTH];
    logic [esmv_pkg::VAL_W-1:0]  r_rd_data;
    logic [esmv_pkg::VLEN_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // hold read data while the consuming stage stalls
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // address zero restarts the count; others advance and stick at the top
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_wr_en) begin
            if (i_wr_addr == '0) begin
                r_count <= esmv_pkg::VLEN_W'(1);
            end else if (r_count != esmv_pkg::COUNT_MAX) begin
                r_count <= r_count + esmv_pkg::VLEN_W'(1);
            end
        end
    end

    assign o_rd_data      = r_rd_data;
    assign o_loaded_count = r_count;

endmodule

>>> rtl/esmv_row_accum.sv
// ----------------------------------------------------------------------------
// esmv_row_accum: product register, saturating row accumulator, result reg
// Multiplies slot value by vector element, sums per row, emits on last slot.
// ----------------------------------------------------------------------------
module esmv_row_accum (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  esmv_pkg::t_slot_ctl                 i_ctl,
    input  logic signed [esmv_pkg::VAL_W-1:0]   i_value,
    input  logic signed [esmv_pkg::VAL_W-1:0]   i_x,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [esmv_pkg::ROW_W-1:0]          o_row_number,
    output logic [esmv_pkg::ACC_W-1:0]          o_row_sum,
    output logic                                o_saturated,
    output logic                                o_bad_column,
    output logic                                o_dimension_error
);

    logic                              r_p_valid;
    esmv_pkg::t_slot_ctl               r_p_ctl;
    logic signed [esmv_pkg::ACC_W-1:0] r_p_prod;

    logic signed [esmv_pkg::ACC_W-1:0] r_acc;
    logic                              r_flag_sat;
    logic                              r_flag_bad;
    logic [esmv_pkg::ROW_W-1:0]        r_row;

    logic                              r_out_valid;
    logic [esmv_pkg::ROW_W-1:0]        r_out_row;
    logic [esmv_pkg::ACC_W-1:0]        r_out_sum;
    logic                              r_out_sat;
    logic                              r_out_bad;
    logic                              r_out_dim;

    logic signed [esmv_pkg::ACC_W-1:0] w_prod;
    logic signed [esmv_pkg::ACC_W-1:0] w_addend;
    logic signed [esmv_pkg::ACC_W-1:0] w_sum;
    logic                              w_ovf;
    logic signed [esmv_pkg::ACC_W-1:0] n_acc;
    logic                              n_sat;
    logic                              n_bad;
    logic                              w_p_go;

    assign w_prod = i_value * i_x;

    // a row end can only leave when the result register is free or draining
    assign w_p_go  = r_p_valid && (!r_p_ctl.last || !r_out_valid || i_ready);
    assign o_ready = !r_p_valid || w_p_go;

    always_comb begin
        w_addend = r_p_ctl.used ? r_p_prod : '0;
        w_sum    = r_acc + w_addend;
        w_ovf    = (r_acc[esmv_pkg::ACC_W-1] == w_addend[esmv_pkg::ACC_W-1]) &&
                   (w_sum[esmv_pkg::ACC_W-1] != r_acc[esmv_pkg::ACC_W-1]);
        if (w_ovf) begin
            n_acc = r_acc[esmv_pkg::ACC_W-1] ? esmv_pkg::ACC_MIN : esmv_pkg::ACC_MAX;
        end else begin
            n_acc = w_sum;
        end
        n_sat = r_flag_sat | w_ovf;
        n_bad = r_flag_bad | r_p_ctl.bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (o_ready) begin
            r_p_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_p_ctl  <= i_ctl;
            r_p_prod <= w_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_flag_sat <= 1'b0;
            r_flag_bad <= 1'b0;
            r_row      <= '0;
        end else if (w_p_go) begin
            if (r_p_ctl.last) begin
                r_acc      <= '0;
                r_flag_sat <= 1'b0;
                r_flag_bad <= 1'b0;
                r_row      <= r_row + esmv_pkg::ROW_W'(1);
            end else begin
                r_acc      <= n_acc;
                r_flag_sat <= n_sat;
                r_flag_bad <= n_bad;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_p_go && r_p_ctl.last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_p_go && r_p_ctl.last) begin
            r_out_row <= r_row;
            r_out_sum <= r_p_ctl.dim ? '0 : n_acc;
            r_out_sat <= n_sat;
            r_out_bad <= n_bad;
            r_out_dim <= r_p_ctl.dim;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_row_number      = r_out_row;
    assign o_row_sum         = r_out_sum;
    assign o_saturated       = r_out_sat;
    assign o_bad_column      = r_out_bad;
    assign o_dimension_error = r_out_dim;

endmodule
